// ===== hw/rtl/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the TDM slot timer
// Field widths, register indexes and the item types handed between cells.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int MAX_SLOTS = 4;
   localparam int FRAC_BITS = 16;

   localparam int TIME_W  = 48;                   // now_time, Q32.16
   localparam int WHOLE_W = TIME_W - FRAC_BITS;   // whole seconds, one divide cell per bit
   localparam int END_W   = 16;                   // slot end, whole seconds
   localparam int CNT_W   = 3;                    // slot_count register
   localparam int OWN_W   = 2;                    // own_slot register
   localparam int SLOT_W  = 2;                    // slot index field
   localparam int CUR_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int START_W = WHOLE_W + 2;          // base + lap + own offset
   localparam int FULL_W  = START_W + FRAC_BITS;  // unmasked next start
   localparam int NEXT_W  = 49;
   localparam int WAIT_W  = 33;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int NUM_END_REGS = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_END_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_SLOT   = 3'd5;

   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   // static view of the configuration, derived from the registers
   typedef struct packed {
      logic [MAX_SLOTS-1:0][END_W-1:0] slot_end;
      logic [CNT_W-1:0]                count;    // clamped to 1..MAX_SLOTS
      logic [OWN_W-1:0]                own;
      logic [END_W-1:0]                cyc;      // cycle length
      logic [END_W-1:0]                own_off;  // start of own slot in the cycle
      logic                            err;      // own slot outside the table
   } cfg_type;

   // item moving down the divider chain
   typedef struct packed {
      logic [TIME_W-1:0]  now;
      logic [END_W-1:0]   rem;
      logic [WHOLE_W-1:0] dvd;   // dividend bits still to be shifted in
   } div_type;

   // item after slot lookup
   typedef struct packed {
      logic [TIME_W-1:0]  now;
      logic [CUR_W-1:0]   cur;
      logic [WHOLE_W-1:0] base;  // cycle number times cycle length
      logic               lap;   // own slot already begun or passed
   } loc_type;

   typedef struct packed {
      logic [SLOT_W-1:0] cur_slot;
      logic              is_own;
      logic [NEXT_W-1:0] next_own_start;
      logic [WAIT_W-1:0] wait_time;
      logic              error;
   } res_type;

endpackage

// ===== hw/rtl/tst_div_cell.sv =====
// ----------------------------------------------------------------------------
// tst_div_cell: one restoring step of the whole-seconds remainder
// Shifts one dividend bit into the partial remainder and subtracts the
// cycle length where it fits; holds one item with its own handshake.
// ----------------------------------------------------------------------------
module tst_div_cell
   import tst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [END_W-1:0] cyc,
   input  logic             in_valid,
   output logic             in_ready,
   input  div_type          in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output div_type          out_data
);

   logic    valid_ff;
   logic    valid_in;
   div_type data_ff;
   div_type data_in;
   logic [END_W:0] trial;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial = {in_data.rem, in_data.dvd[WHOLE_W-1]};
      data_in.now = in_data.now;
      data_in.dvd = {in_data.dvd[WHOLE_W-2:0], 1'b0};
      if (trial >= {1'b0, cyc}) begin
         data_in.rem = END_W'(trial - {1'b0, cyc});
      end else begin
         data_in.rem = trial[END_W-1:0];
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tst_locate.sv =====
// ----------------------------------------------------------------------------
// tst_locate: position within the cycle and current slot
// Priority scan of the slot ends against the position; also forms the
// start of the current cycle from the remainder.
// ----------------------------------------------------------------------------
module tst_locate
   import tst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output loc_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   loc_type data_ff;
   loc_type data_in;
   logic [TIME_W-1:0]  pos;
   logic [WHOLE_W-1:0] whole;
   logic [CUR_W-1:0]   cur;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      whole = in_data.now[TIME_W-1:FRAC_BITS];
      if (cfg.cyc == '0) begin
         pos = in_data.now;
      end else begin
         pos = TIME_W'({in_data.rem, in_data.now[FRAC_BITS-1:0]});
      end

      // lowest matching entry wins: scan from the top down
      cur = CUR_W'(cfg.count - CNT_W'(1));
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (i < 32'(cfg.count) &&
             {cfg.slot_end[i], {FRAC_BITS{1'b0}}} > (END_W + FRAC_BITS)'(pos)
             && pos[TIME_W-1 -: (TIME_W - END_W - FRAC_BITS)] == '0) begin
            cur = CUR_W'(i);
         end
      end

      data_in.now  = in_data.now;
      data_in.cur  = cur;
      data_in.base = (cfg.cyc == '0) ? '0 : whole - WHOLE_W'(in_data.rem);
      data_in.lap  = 32'(cur) >= 32'(cfg.own);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tst_schedule.sv =====
// ----------------------------------------------------------------------------
// tst_schedule: next own slot start and wait, output register
// Adds lap and own offset to the cycle start, then the saturated wait.
// ----------------------------------------------------------------------------
module tst_schedule
   import tst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  loc_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   res_type data_ff;
   res_type data_in;
   logic [START_W-1:0] start_s;
   logic [FULL_W-1:0]  next;
   logic [FULL_W-1:0]  now_x;
   logic [FULL_W-1:0]  diff;
   logic [WAIT_W-1:0]  wait_v;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      start_s = START_W'(in_data.base)
              + (in_data.lap ? START_W'(cfg.cyc) : '0)
              + START_W'(cfg.own_off);
      next  = {start_s, {FRAC_BITS{1'b0}}};
      now_x = FULL_W'(in_data.now);
      diff  = next - now_x;
      if (next <= now_x) begin
         wait_v = '0;
      end else if (diff > FULL_W'(WAIT_MAX)) begin
         wait_v = WAIT_MAX;
      end else begin
         wait_v = diff[WAIT_W-1:0];
      end

      data_in.cur_slot = SLOT_W'(in_data.cur);
      if (cfg.err) begin
         data_in.is_own         = 1'b0;
         data_in.next_own_start = '0;
         data_in.wait_time      = '0;
         data_in.error          = 1'b1;
      end else begin
         data_in.is_own         = 32'(in_data.cur) == 32'(cfg.own);
         data_in.next_own_start = next[NEXT_W-1:0];
         data_in.wait_time      = wait_v;
         data_in.error          = 1'b0;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tdm_slot_timer_unit.sv =====
// ----------------------------------------------------------------------------
// tdm_slot_timer_unit: TDM slot schedule lookup
// Maps a Q32.16 time to the current slot and the next own slot start.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one item per time value (req_now_time), valid/ready.
//  - rsp_ channel: one item per request, in order: current slot, own flag,
//    next own slot start (Q33.16), wait until then (Q17.16), error flag.
//  - csr_ port: write-only, csr_we with csr_index 0..3 slot ends, 4 slot
//    count, 5 own slot; other indexes are ignored. Write only while idle.
//  - Stages: 32 divider cells (one remainder bit each, set by the 32-bit
//    whole-seconds part), slot lookup, then the output register.
//  - Unless stalled, one item per cycle; every cell holds one item and takes
//    a new one whenever it is empty or its neighbor takes its item.
//  - A stalled receiver fills the chain from the output end back; bubbles
//    in front still accept new items until the chain is full.
//  - Synchronous reset empties the chain and loads slot ends 1,2,3,4,
//    slot count 4 and own slot 0.
// ----------------------------------------------------------------------------
module tdm_slot_timer_unit
   import tst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_now_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SLOT_W-1:0]    rsp_current_slot,
   output logic                 rsp_is_own,
   output logic [NEXT_W-1:0]    rsp_next_own_start,
   output logic [WAIT_W-1:0]    rsp_wait_time,
   output logic                 rsp_error,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // configuration registers
   logic [MAX_SLOTS-1:0][END_W-1:0] slot_end_ff;
   logic [MAX_SLOTS-1:0][END_W-1:0] slot_end_in;
   logic [CNT_W-1:0]                slot_count_ff;
   logic [CNT_W-1:0]                slot_count_in;
   logic [OWN_W-1:0]                own_slot_ff;
   logic [OWN_W-1:0]                own_slot_in;

   cfg_type cfg;

   always_comb begin
      slot_end_in   = slot_end_ff;
      slot_count_in = slot_count_ff;
      own_slot_in   = own_slot_ff;
      if (csr_we) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i < NUM_END_REGS && csr_index == CSR_SLOT_END_0 + CSR_IDX_W'(i)) begin
               slot_end_in[i] = csr_wdata[END_W-1:0];
            end
         end
         if (csr_index == CSR_SLOT_COUNT) begin
            slot_count_in = csr_wdata[CNT_W-1:0];
         end
         if (csr_index == CSR_OWN_SLOT) begin
            own_slot_in = csr_wdata[OWN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_end_ff[i] <= END_W'(i + 1);
         end
         slot_count_ff <= CNT_W'(4);
         own_slot_ff   <= '0;
      end else begin
         slot_end_ff   <= slot_end_in;
         slot_count_ff <= slot_count_in;
         own_slot_ff   <= own_slot_in;
      end
   end

   // derived view: clamped count, cycle length, own slot offset
   always_comb begin
      cfg.slot_end = slot_end_ff;
      cfg.own      = own_slot_ff;
      if (slot_count_ff == '0) begin
         cfg.count = CNT_W'(1);
      end else if (32'(slot_count_ff) > MAX_SLOTS) begin
         cfg.count = CNT_W'(MAX_SLOTS);
      end else begin
         cfg.count = slot_count_ff;
      end
      cfg.cyc     = '0;
      cfg.own_off = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (32'(cfg.count) == i + 1) begin
            cfg.cyc = slot_end_ff[i];
         end
      end
      for (int i = 1; i < MAX_SLOTS; i++) begin
         if (32'(own_slot_ff) == i) begin
            cfg.own_off = slot_end_ff[i-1];
         end
      end
      cfg.err = 32'(own_slot_ff) >= 32'(cfg.count);
   end

   // divider chain: whole seconds modulo cycle length
   logic    chain_valid [WHOLE_W+1];
   logic    chain_ready [WHOLE_W+1];
   div_type chain_data  [WHOLE_W+1];

   assign chain_valid[0]    = req_valid;
   assign req_ready         = chain_ready[0];
   assign chain_data[0].now = req_now_time;
   assign chain_data[0].rem = '0;
   assign chain_data[0].dvd = req_now_time[TIME_W-1:FRAC_BITS];

   for (genvar g = 0; g < WHOLE_W; g++) begin : g_div
      tst_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cyc       (cfg.cyc),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // slot lookup
   logic    loc_valid;
   logic    loc_ready;
   loc_type loc_data;

   tst_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (chain_valid[WHOLE_W]),
      .in_ready  (chain_ready[WHOLE_W]),
      .in_data   (chain_data[WHOLE_W]),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_data  (loc_data)
   );

   // next own start, wait, output register
   res_type res;

   tst_schedule u_schedule (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (loc_valid),
      .in_ready  (loc_ready),
      .in_data   (loc_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (res)
   );

   assign rsp_current_slot   = res.cur_slot;
   assign rsp_is_own         = res.is_own;
   assign rsp_next_own_start = res.next_own_start;
   assign rsp_wait_time      = res.wait_time;
   assign rsp_error          = res.error;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the TDM slot timer
// Drives time values on the req_ channel, predicts slot, own flag, next own
// start, wait and error flag per item, and checks every rsp_ item in order.
// A directed table comes first, then randomized phases over many schedules.
// ----------------------------------------------------------------------------
module tb_top;
   import tst_pkg::*;

   localparam int PIPE_LATENCY  = 34;       // divider cells + lookup + output reg
   localparam int CYCLE_LIMIT   = 300000;   // watchdog
   localparam int HOLD_CYCLES   = 200;      // long receiver hold-off, fills the chain
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 80;
   localparam int REPORT_LIMIT  = 20;       // mismatch lines printed at most

   // extra register indexes used by the directed table
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_END_1 = CSR_SLOT_END_0 + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_END_2 = CSR_SLOT_END_0 + 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_END_3 = CSR_SLOT_END_0 + 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 3'd6;   // ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 3'd7;   // ignored by the block

   // directed table: a register write, a query checked by the predictor, or a
   // query whose result is typed in
   typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CSR_DAT_W-1:0] reg_data;
      logic [TIME_W-1:0]    now;
      res_type              exp;
   } dir_row_type;

   localparam res_type NO_RES = '0;
   localparam int DIR_ROWS = 42;

   localparam dir_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      // reset schedule: ends 1,2,3,4, own slot 0
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h0,
        '{2'd0, 1'b1, 49'h4_0000, 33'h4_0000, 1'b0}},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h1_8000,
        '{2'd1, 1'b0, 49'h4_0000, 33'h2_8000, 1'b0}},
      // largest time: next start lands on 2^32 s, one tick away
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'hFFFF_FFFF_FFFF,
        '{2'd3, 1'b0, 49'h1_0000_0000_0000, 33'h1, 1'b0}},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h3_FFFF, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h4_0000, NO_RES},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h3, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h2_0000, NO_RES},
      // own slot outside the table
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h2, 48'h0, NO_RES},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h5_0000,
        '{2'd1, 1'b0, 49'h0, 33'h0, 1'b1}},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h2, 48'h0, NO_RES},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h0,
        '{2'd0, 1'b0, 49'h0, 33'h0, 1'b1}},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h1, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h1234_5678_9ABC, NO_RES},
      // slot count 0 acts as 1
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h0, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h0, 48'h0, NO_RES},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h7_1234,
        '{2'd0, 1'b1, 49'h8_0000, 33'h0_EDCC, 1'b0}},
      // slot count above the table acts as full table
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h7, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h8000_0000_0001, NO_RES},
      // widest ends
      '{ROW_WRITE,   CSR_SLOT_END_0, 16'h0001, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_END_1, 16'h8000, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_END_2, 16'hFFFE, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_END_3, 16'hFFFF, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h4, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h3, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'hFFFF_FFFF_FFFF, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'hFFFE_FFFF, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h0, NO_RES},
      // table not ascending: own start already behind, wait clamps to zero
      '{ROW_WRITE,   CSR_SLOT_END_0, 16'd50, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_END_1, 16'd2,  48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_END_2, 16'd10, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h3, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h2, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h5_0000, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'h1_0000, NO_RES},
      // zero cycle length: no reduction, no slot end above position
      '{ROW_WRITE,   CSR_SLOT_END_0, 16'h0, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_SLOT_COUNT, 16'h1, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_OWN_SLOT,   16'h0, 48'h0, NO_RES},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h1234_5678,
        '{2'd0, 1'b1, 49'h0, 33'h0, 1'b0}},
      '{ROW_CHECKED, CSR_SLOT_END_0, 16'h0, 48'h0,
        '{2'd0, 1'b1, 49'h0, 33'h0, 1'b0}},
      // writes to unmapped indexes change nothing
      '{ROW_WRITE,   CSR_UNMAPPED_A, 16'hFFFF, 48'h0, NO_RES},
      '{ROW_WRITE,   CSR_UNMAPPED_B, 16'hFFFF, 48'h0, NO_RES},
      '{ROW_QUERY,   CSR_SLOT_END_0, 16'h0, 48'hABCD_0000, NO_RES}
   };

   // DUT signals; the ones the bench drives are known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SLOT_W-1:0]    rsp_current_slot;
   logic                 rsp_is_own;
   logic [NEXT_W-1:0]    rsp_next_own_start;
   logic [WAIT_W-1:0]    rsp_wait_time;
   logic                 rsp_error;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // mirror of the schedule registers
   logic [END_W-1:0] sched_end [MAX_SLOTS];
   logic [CNT_W-1:0] sched_count;
   logic [OWN_W-1:0] sched_own;

   res_type     pending_results [$];
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned error_results = 0;
   int unsigned own_hits = 0;
   int unsigned schedules_used = 0;
   int unsigned mismatches = 0;

   tdm_slot_timer_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_slot   (rsp_current_slot),
      .rsp_is_own         (rsp_is_own),
      .rsp_next_own_start (rsp_next_own_start),
      .rsp_wait_time      (rsp_wait_time),
      .rsp_error          (rsp_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still pending",
                  $time, cycle_count, pending_results.size());
         $display("** tdm_slot_timer_unit: FAILED **");
         $finish;
      end
   end

   // Slot lookup for one time value under the mirrored schedule.
   function automatic res_type slot_lookup(input logic [TIME_W-1:0] now);
      res_type     r;
      int unsigned used;
      int unsigned cur;
      int unsigned own;
      logic [63:0] cyc, whole, num, pos, start_s, nxt, gap;
      bit          found;
      r     = '0;
      used  = (sched_count == 0) ? 1 :
              (sched_count > MAX_SLOTS) ? MAX_SLOTS : int'(sched_count);
      cyc   = 64'(sched_end[used-1]);
      whole = 64'(now >> FRAC_BITS);
      if (cyc != 0) begin
         num = whole / cyc;
         pos = ((whole - num * cyc) << FRAC_BITS) + 64'(now[FRAC_BITS-1:0]);
      end else begin
         // zero cycle length: position is the raw time
         num = 0;
         pos = 64'(now);
      end
      // priority scan from slot 0; falls back to the last used slot
      cur   = used - 1;
      found = 1'b0;
      for (int i = 0; i < used; i++) begin
         if (!found && (64'(sched_end[i]) << FRAC_BITS) > pos) begin
            cur   = i;
            found = 1'b1;
         end
      end
      r.cur_slot = cur[SLOT_W-1:0];
      own = 32'(sched_own);
      if (own >= used) begin
         r.error = 1'b1;
         return r;
      end
      start_s = num * cyc;
      if (cur >= own) start_s += cyc;          // own slot begun or passed: next lap
      if (own > 0) start_s += 64'(sched_end[own-1]);
      nxt = start_s << FRAC_BITS;
      gap = (nxt > 64'(now)) ? nxt - 64'(now) : 64'd0;
      if (gap > 64'(WAIT_MAX)) gap = 64'(WAIT_MAX);
      r.is_own         = (cur == own);
      r.next_own_start = nxt[NEXT_W-1:0];
      r.wait_time      = gap[WAIT_W-1:0];
      return r;
   endfunction

   // Random time value, biased toward slot edges of the current schedule.
   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned    used;
      logic [63:0]    cyc, whole, lap;
      logic [15:0]    frac;
      used = (sched_count == 0) ? 1 :
             (sched_count > MAX_SLOTS) ? MAX_SLOTS : int'(sched_count);
      cyc  = 64'(sched_end[used-1]);
      frac = 16'($urandom());
      case ($urandom_range(0, 3))
         0: whole = 64'($urandom());
         1: whole = 64'($urandom_range(0, 300));
         2: begin
            // straddle a slot end in some lap
            lap   = ($urandom_range(0, 3) == 0) ? 64'($urandom() >> 16)
                                                : 64'($urandom_range(0, 5));
            whole = lap * cyc + 64'(sched_end[$urandom_range(0, used-1)])
                    + 64'($urandom_range(0, 2)) - 64'd1;
            case ($urandom_range(0, 2))
               0: frac = '0;
               1: frac = '1;
               default: ;
            endcase
         end
         default: whole = 64'(32'hFFFF_FFFF - $urandom_range(0, 70000));
      endcase
      return {whole[WHOLE_W-1:0], frac};
   endfunction

   // One register write; csr_we stays up for a following write, the caller
   // lowers it after the last one.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx < CSR_SLOT_END_0 + NUM_END_REGS)
         sched_end[idx - CSR_SLOT_END_0] = data[END_W-1:0];
      else if (idx == CSR_SLOT_COUNT)
         sched_count = data[CNT_W-1:0];
      else if (idx == CSR_OWN_SLOT)
         sched_own = data[OWN_W-1:0];
   endtask

   task automatic await_empty_pipe();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Offer one time value, hold it until taken, then queue its expected result (typed in or predicted).
   task automatic send_item(input logic [TIME_W-1:0] t, input bit typed_row,
                            input res_type typed);
      if (send_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_now_time <= t;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(typed_row ? typed : slot_lookup(t));
      items_sent++;
   endtask

   // Schedule for one random phase; block must be idle on entry.
   task automatic load_schedule(input int phase);
      logic [CSR_DAT_W-1:0] ends [MAX_SLOTS];
      logic [CSR_DAT_W-1:0] count_val;
      logic [CSR_DAT_W-1:0] own_val;
      int unsigned          step_max;
      int unsigned          acc;
      step_max  = 0;
      acc       = 0;
      count_val = CSR_DAT_W'(MAX_SLOTS);
      own_val   = CSR_DAT_W'($urandom_range(0, 3));
      case (phase)
         2: begin
            ends    = '{16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF};
            own_val = 16'd3;
         end
         3: begin
            ends    = '{16'h0001, 16'h0002, 16'hFFFE, 16'hFFFF};
            own_val = 16'd1;
         end
         7, 9: begin
            // unordered table, zeros included, any slot count
            for (int i = 0; i < MAX_SLOTS; i++)
               ends[i] = ($urandom_range(0, 3) == 0) ? 16'd0 :
                         (phase == 7) ? 16'($urandom()) : 16'($urandom_range(0, 20));
            count_val = CSR_DAT_W'($urandom_range(0, 7));
            if (phase == 7) begin
               // junk above the field must be dropped
               count_val[CSR_DAT_W-1:CNT_W] = (CSR_DAT_W - CNT_W)'($urandom());
               own_val[CSR_DAT_W-1:OWN_W]   = (CSR_DAT_W - OWN_W)'($urandom());
            end
         end
         default: step_max = (phase == 0) ? 8 : 16383;
      endcase
      if (step_max != 0) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            acc     = acc + $urandom_range(1, step_max);
            ends[i] = acc[CSR_DAT_W-1:0];
         end
      end
      if (phase == 1 || phase == 8) count_val = CSR_DAT_W'($urandom_range(1, MAX_SLOTS));
      if (phase == 4) count_val = 16'd1;
      if (phase == 6) count_val = ($urandom_range(0, 3) == 0) ? 16'd0
                                                              : 16'($urandom_range(5, 7));
      for (int i = 0; i < MAX_SLOTS; i++)
         csr_write(CSR_SLOT_END_0 + CSR_IDX_W'(i), ends[i]);
      csr_write(CSR_SLOT_COUNT, count_val);
      csr_write(CSR_OWN_SLOT, own_val);
      csr_we <= 1'b0;
      schedules_used++;
   endtask

   task automatic note_mismatch(input string field, input logic [63:0] exp,
                                input logic [63:0] act);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
   endtask

   // Receiver: checks each taken item, then decides ready for the next edge.
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      bit          hold_done;
      res_type     exp;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_error) error_results++;
            if (rsp_is_own) own_hits++;
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected item", 64'd0, 64'd1);
            end else begin
               exp = pending_results.pop_front();
               if (rsp_current_slot !== exp.cur_slot)
                  note_mismatch("slot index", 64'(exp.cur_slot),
                                64'(rsp_current_slot));
               if (rsp_is_own !== exp.is_own)
                  note_mismatch("is_own", 64'(exp.is_own), 64'(rsp_is_own));
               if (rsp_next_own_start !== exp.next_own_start)
                  note_mismatch("next_own_start", 64'(exp.next_own_start),
                                64'(rsp_next_own_start));
               if (rsp_wait_time !== exp.wait_time)
                  note_mismatch("wait_time", 64'(exp.wait_time), 64'(rsp_wait_time));
               if (rsp_error !== exp.error)
                  note_mismatch("error", 64'(exp.error), 64'(rsp_error));
            end
         end
         // one long hold-off on request, else random stall bursts
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus: directed table, then random phases, then drain and verdict.
   initial begin : req_side
      for (int i = 0; i < MAX_SLOTS; i++) sched_end[i] = END_W'(i + 1);
      sched_count = CNT_W'(MAX_SLOTS);
      sched_own   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      schedules_used = 1;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TABLE[r].kind == ROW_WRITE) begin
            // registers change only with the pipe empty
            if (r == 0 || DIR_TABLE[r-1].kind != ROW_WRITE) begin
               req_valid <= 1'b0;
               await_empty_pipe();
               schedules_used++;
            end
            csr_write(DIR_TABLE[r].reg_index, DIR_TABLE[r].reg_data);
            if (r == DIR_ROWS - 1 || DIR_TABLE[r+1].kind != ROW_WRITE)
               csr_we <= 1'b0;
         end else begin
            send_item(DIR_TABLE[r].now, DIR_TABLE[r].kind == ROW_CHECKED,
                      DIR_TABLE[r].exp);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         await_empty_pipe();
         load_schedule(phase);
         // phase 3 runs without idling, phase 5 sends without idling; last two phases run flat out
         send_idle_on = (phase != 3) && (phase != 5) && (phase < 8);
         recv_idle_on = (phase != 3) && (phase < 8);
         if (phase == 5) hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_item(pick_time(), 1'b0, NO_RES);
      end
      req_valid <= 1'b0;

      await_empty_pipe();
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Covered %0d time values over %0d schedules; %0d items checked,",
               items_sent, schedules_used, results_seen);
      $display("%0d with own slot error, %0d in own slot, one %0d-cycle receiver hold-off.",
               error_results, own_hits, HOLD_CYCLES);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** tdm_slot_timer_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d items missing", mismatches, pending_results.size());
         $display("** tdm_slot_timer_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tst_pkg.sv
hw/rtl/tst_div_cell.sv
hw/rtl/tst_locate.sv
hw/rtl/tst_schedule.sv
hw/rtl/tdm_slot_timer_unit.sv
tb/sv/tb_top.sv
